// ----- rtl/mnp_pkg.sv -----
// mnp_pkg: shared constants and the top-octave frequency table for the
// midi note message parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mnp_pkg;

	localparam int unsigned CHAN_W = 4;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NOTE_W = 7;
	localparam int unsigned FREQ_W = 22;
	localparam int unsigned TBL_W  = 32;

	// status nibbles and byte codes
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;
	localparam logic [BYTE_W-1:0] STATUS_NONE = 8'h00;

	// note number of the lowest entry of the top octave
	localparam logic [7:0] TOP_OCT_BASE = 8'd116;
	localparam logic [4:0] SHIFT_BASE   = 5'd10;

	// top octave (notes 116..127) in Hz, unsigned q18
	function automatic logic [TBL_W-1:0] top_octave_q18(input logic [3:0] idx);
		logic [TBL_W-1:0] v;
		begin
			unique case (idx)
				4'd0:    v = 32'd1741914250;
				4'd1:    v = 32'd1845493760;
				4'd2:    v = 32'd1955232745;
				4'd3:    v = 32'd2071496478;
				4'd4:    v = 32'd2194674310;
				4'd5:    v = 32'd2325176692;
				4'd6:    v = 32'd2463438350;
				4'd7:    v = 32'd2609922305;
				4'd8:    v = 32'd2765116665;
				4'd9:    v = 32'd2929538413;
				4'd10:   v = 32'd3103738174;
				4'd11:   v = 32'd3288296412;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mnp_note_freq.sv -----
// mnp_note_freq: equal-tempered frequency of a note number, unsigned q14.8.
// Octave reduction by reciprocal multiply, top-octave table and a rounded
// shift. Depends on mnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnp_note_freq (
	input  wire logic [mnp_pkg::NOTE_W-1:0] note,
	output logic      [mnp_pkg::FREQ_W-1:0] freq_q8
);

	logic [6:0]  below_top;
	logic [14:0] prod;
	logic [3:0]  oct;
	logic [7:0]  oct_x12;
	logic [7:0]  idx_full;
	logic [4:0]  shamt;
	logic [32:0] rounded;
	logic [32:0] shifted;

	// octaves below the top one: (127 - n) / 12, exact for 7-bit values
	always_comb begin
		below_top = 7'd127 - note;
		prod      = {8'd0, below_top} * 15'd171;
		oct       = prod[14:11];
		oct_x12   = {4'd0, oct} * 8'd12;
		idx_full  = {1'b0, note} + oct_x12 - mnp_pkg::TOP_OCT_BASE;
		shamt     = mnp_pkg::SHIFT_BASE + {1'b0, oct};
		rounded   = {1'b0, mnp_pkg::top_octave_q18(idx_full[3:0])}
			+ (33'd1 << (shamt - 5'd1));
		shifted   = rounded >> shamt;
		freq_q8   = shifted[mnp_pkg::FREQ_W-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/midi_note_message_parser.sv -----
// midi_note_message_parser: top level, running status tracking and note
// event output. Depends on mnp_pkg and mnp_note_freq.
//
// Usage:
//   Input channel: one received midi word per handshake (in_valid/in_ready,
//   midi_byte). Output channel: one note event per completed note/velocity
//   pair (out_valid/out_ready, gate_on, note_number, velocity, frequency_q8).
//   cfg_we/cfg_wdata write listen_channel; write it only while idle.
//   Path: an accepted word is captured in the input register; its event,
//   if any, then goes into the result register and is offered from there.
//   Throughput: one word per cycle unless an event waits on a held output,
//   set by the single decode pass between the input and result registers.
//   Stall: a waiting event holds in the result register; words that cause
//   no event keep flowing, a word that causes one waits in the input
//   register, and in_ready drops only when both registers are held.
//   Reset: running status, pending note and listen_channel clear to zero;
//   both channels come up empty.
`timescale 1ns / 1ps
`default_nettype none

module midi_note_message_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [mnp_pkg::CHAN_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [mnp_pkg::BYTE_W-1:0]   midi_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              gate_on,
	output logic      [mnp_pkg::NOTE_W-1:0]   note_number,
	output logic      [mnp_pkg::NOTE_W-1:0]   velocity,
	output logic      [mnp_pkg::FREQ_W-1:0]   frequency_q8
);

	logic [mnp_pkg::CHAN_W-1:0] listen_channel_q;
	logic [mnp_pkg::BYTE_W-1:0] running_status_q;
	logic [mnp_pkg::NOTE_W-1:0] pending_note_q;
	logic                       note_pending_q;

	logic                       s1_valid_s1;
	logic [mnp_pkg::BYTE_W-1:0] s1_byte_s1;

	logic                       out_valid_q;
	logic                       gate_on_q;
	logic [mnp_pkg::NOTE_W-1:0] note_q;
	logic [mnp_pkg::NOTE_W-1:0] vel_q;
	logic [mnp_pkg::FREQ_W-1:0] freq_q;

	logic                       is_data;
	logic                       is_voice;
	logic                       is_common;
	logic                       match_off;
	logic                       match_on;
	logic                       has_result;
	logic                       takes_note;
	logic                       out_free;
	logic                       advance;
	logic                       note_on;
	logic [mnp_pkg::NOTE_W-1:0] data7;
	logic [mnp_pkg::FREQ_W-1:0] lut_freq;

	mnp_note_freq u_freq (
		.note    (pending_note_q),
		.freq_q8 (lut_freq)
	);

	// decode of the word in the input register
	always_comb begin
		data7      = s1_byte_s1[mnp_pkg::NOTE_W-1:0];
		is_data    = !s1_byte_s1[7];
		is_voice   = s1_byte_s1[7] && (s1_byte_s1[7:4] != mnp_pkg::NIB_SYSTEM);
		is_common  = (s1_byte_s1[7:4] == mnp_pkg::NIB_SYSTEM) && !s1_byte_s1[3];
		match_off  = running_status_q == {mnp_pkg::NIB_NOTE_OFF, listen_channel_q};
		match_on   = running_status_q == {mnp_pkg::NIB_NOTE_ON, listen_channel_q};
		has_result = is_data && (match_off || match_on) && note_pending_q;
		takes_note = is_data && (match_off || match_on) && !note_pending_q;
		note_on    = match_on && (data7 != '0);
		out_free   = !out_valid_q || out_ready;
		advance    = s1_valid_s1 && (!has_result || out_free);
		in_ready   = !s1_valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_channel_q <= '0;
		end else if (cfg_we) begin
			listen_channel_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_byte_s1 <= midi_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_status_q <= mnp_pkg::STATUS_NONE;
			pending_note_q   <= '0;
			note_pending_q   <= 1'b0;
		end else if (advance) begin
			priority if (is_voice) begin
				running_status_q <= s1_byte_s1;
				pending_note_q   <= '0;
				note_pending_q   <= 1'b0;
			end else if (is_common) begin
				running_status_q <= mnp_pkg::STATUS_NONE;
			end else if (takes_note) begin
				pending_note_q <= data7;
				note_pending_q <= 1'b1;
			end else if (has_result) begin
				pending_note_q <= '0;
				note_pending_q <= 1'b0;
			end else begin
				// real-time words and unmatched data leave the state as is
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			gate_on_q <= note_on;
			note_q    <= pending_note_q;
			vel_q     <= data7;
			freq_q    <= note_on ? lut_freq : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign gate_on      = gate_on_q;
	assign note_number  = note_q;
	assign velocity     = vel_q;
	assign frequency_q8 = freq_q;

	a_on_has_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && gate_on_q |-> (freq_q != '0) && (vel_q != '0))
		else $error("note on without frequency or velocity");

	a_off_no_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !gate_on_q |-> freq_q == '0)
		else $error("note off with nonzero frequency");

	a_voice_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_voice |=> !note_pending_q)
		else $error("voice status left a note pending");

	a_pair_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> !note_pending_q && out_valid_q)
		else $error("completed pair not delivered or not cleared");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !advance |=> s1_valid_s1 && $stable(s1_byte_s1))
		else $error("held input word lost");

endmodule

`default_nettype wire

// ----- verif/midi_note_message_parser_test.sv -----
// midi_note_message_parser_test: self-checking bench for the midi note parser.
// Drives midi words in random bursts, predicts note events and checks each one.
// Depends on mnp_pkg and the midi_note_message_parser RTL.
`timescale 1ns / 1ps

module midi_note_message_parser_test;

	localparam logic [7:0] VOICE_LO    = 8'h80;
	localparam logic [7:0] VOICE_HI    = 8'hEF;
	localparam logic [7:0] COMMON_LO   = 8'hF0;
	localparam logic [7:0] COMMON_HI   = 8'hF7;
	localparam logic [7:0] REALTIME_LO = 8'hF8;
	localparam logic [7:0] REALTIME_HI = 8'hFF;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned PHASE_WORDS = 190;

	// top octave, notes 116..127, hz in q18; entry 0 in the low bits
	localparam logic [12*32-1:0] OCTAVE_Q18 = {
		32'd3288296412, 32'd3103738174, 32'd2929538413, 32'd2765116665,
		32'd2609922305, 32'd2463438350, 32'd2325176692, 32'd2194674310,
		32'd2071496478, 32'd1955232745, 32'd1845493760, 32'd1741914250
	};

	typedef struct packed {
		logic                          gate;
		logic [mnp_pkg::NOTE_W-1:0]    note;
		logic [mnp_pkg::NOTE_W-1:0]    vel;
		logic [mnp_pkg::FREQ_W-1:0]    freq;
	} note_event_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [mnp_pkg::CHAN_W-1:0]    cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [mnp_pkg::BYTE_W-1:0]    midi_byte = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          gate_on;
	logic [mnp_pkg::NOTE_W-1:0]    note_number;
	logic [mnp_pkg::NOTE_W-1:0]    velocity;
	logic [mnp_pkg::FREQ_W-1:0]    frequency_q8;

	logic [7:0]   midi_words_q[$];
	note_event_t  note_events_due[$];
	logic         in_taken = 1'b0;
	int           mismatches = 0;

	// parser shadow state
	logic [mnp_pkg::CHAN_W-1:0]    chan_shadow = '0;
	logic [7:0]                    status_shadow = mnp_pkg::STATUS_NONE;
	logic [mnp_pkg::NOTE_W-1:0]    held_note = '0;
	logic                          note_held = 1'b0;

	int           burst_left = 0;
	int           gap_left = 0;
	logic [15:0]  stall_pattern = 16'hFFFF;
	int           stall_pos = 0;

	midi_note_message_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.midi_byte    (midi_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gate_on      (gate_on),
		.note_number  (note_number),
		.velocity     (velocity),
		.frequency_q8 (frequency_q8)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [mnp_pkg::FREQ_W-1:0] pitch_q8(input logic [6:0] n);
		int unsigned nn;
		int unsigned oct;
		int unsigned idx;
		int unsigned sh;
		logic [63:0] v;
		nn = n;
		oct = (127 - nn) / 12;
		idx = nn + 12 * oct - 116;
		sh = 10 + oct;
		v = {32'd0, OCTAVE_Q18[idx*32 +: 32]};
		v = (v + (64'd1 << (sh - 1))) >> sh;
		return v[mnp_pkg::FREQ_W-1:0];
	endfunction

	task automatic track_word(input logic [7:0] b);
		note_event_t ev;
		logic        on;
		if (b >= VOICE_LO && b <= VOICE_HI) begin
			status_shadow = b;
			held_note = '0;
			note_held = 1'b0;
		end else if (b >= COMMON_LO && b <= COMMON_HI) begin
			status_shadow = mnp_pkg::STATUS_NONE;
		end else if (b >= REALTIME_LO) begin
			// real-time words pass through untouched
		end else if (status_shadow == mnp_pkg::STATUS_NONE) begin
		end else if (status_shadow != {mnp_pkg::NIB_NOTE_OFF, chan_shadow} &&
				status_shadow != {mnp_pkg::NIB_NOTE_ON, chan_shadow}) begin
		end else if (!note_held) begin
			held_note = b[6:0];
			note_held = 1'b1;
		end else begin
			on = (status_shadow == {mnp_pkg::NIB_NOTE_ON, chan_shadow}) && (b[6:0] != 0);
			ev.gate = on;
			ev.note = held_note;
			ev.vel = b[6:0];
			ev.freq = on ? pitch_q8(held_note) : '0;
			note_events_due.push_back(ev);
			held_note = '0;
			note_held = 1'b0;
		end
	endtask

	task automatic report_event(input string why, input note_event_t want,
			input note_event_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected gate %0d note %0d vel %0d freq %0d, ",
				"got gate %0d note %0d vel %0d freq %0d"},
				$realtime, why, want.gate, want.note, want.vel, want.freq,
				got.gate, got.note, got.vel, got.freq);
	endtask

	// driver: bursts of words with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (burst_left == 0) begin
				if (gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					gap_left--;
				end
			end
			if (burst_left != 0 && midi_words_q.size() != 0) begin
				in_valid <= 1'b1;
				midi_byte <= midi_words_q.pop_front();
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				midi_byte <= 8'($urandom_range(0, 255));
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_pos == 0) begin
			if ($urandom_range(0, 2) == 0)
				stall_pattern = 16'hFFFF;
			else
				stall_pattern = 16'($urandom_range(0, 16'hFFFF));
		end
		out_ready <= arst_n && stall_pattern[stall_pos % 16];
		stall_pos = (stall_pos + 1) % 64;
	end

	// monitor: predict on accepted words, check accepted events
	always @(posedge clk) begin
		note_event_t got;
		note_event_t want;
		if (arst_n && out_valid && out_ready) begin
			got.gate = gate_on;
			got.note = note_number;
			got.vel = velocity;
			got.freq = frequency_q8;
			if (note_events_due.size() == 0) begin
				report_event("unexpected event", '0, got);
			end else begin
				want = note_events_due.pop_front();
				if (got.gate !== want.gate || got.note !== want.note ||
						got.vel !== want.vel || got.freq !== want.freq)
					report_event("event mismatch", want, got);
			end
		end
		if (arst_n && in_valid && in_ready)
			track_word(midi_byte);
		in_taken <= arst_n && in_valid && in_ready;
	end

	task automatic wait_idle();
		while (midi_words_q.size() != 0 || in_valid || note_events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_channel(input logic [3:0] ch);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= ch;
		@(negedge clk);
		cfg_we <= 1'b0;
		chan_shadow = ch;
	endtask

	task automatic queue_note_traffic(input int n, input logic [3:0] ch);
		int          pushed;
		int          pairs;
		logic [7:0]  note;
		logic [7:0]  vel;
		pushed = 0;
		while (pushed < n) begin
			case ($urandom_range(0, 99)) inside
				[0:59]: begin
					if ($urandom_range(0, 1) == 0) begin
						midi_words_q.push_back(($urandom_range(0, 1) == 0) ?
							{mnp_pkg::NIB_NOTE_ON, ch} : {mnp_pkg::NIB_NOTE_OFF, ch});
						pushed++;
					end
					pairs = $urandom_range(1, 4);
					repeat (pairs) begin
						note = 8'($urandom_range(0, 127));
						vel = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(0, 127));
						midi_words_q.push_back(note);
						if ($urandom_range(0, 9) == 0)
							midi_words_q.push_back(8'($urandom_range(REALTIME_LO, REALTIME_HI)));
						midi_words_q.push_back(vel);
						pushed += 2;
					end
				end
				[60:69]: begin
					midi_words_q.push_back(($urandom_range(0, 1) == 0) ?
						{4'($urandom_range(8, 14)), 4'(ch + $urandom_range(1, 15))} :
						{4'($urandom_range(10, 14)), ch});
					midi_words_q.push_back(8'($urandom_range(0, 127)));
					midi_words_q.push_back(8'($urandom_range(0, 127)));
					pushed += 3;
				end
				[70:77]: begin
					midi_words_q.push_back(8'($urandom_range(COMMON_LO, COMMON_HI)));
					midi_words_q.push_back(8'($urandom_range(0, 127)));
					pushed += 2;
				end
				[78:87]: begin
					midi_words_q.push_back(8'($urandom_range(REALTIME_LO, REALTIME_HI)));
					pushed++;
				end
				default: begin
					midi_words_q.push_back(8'($urandom_range(0, 255)));
					pushed++;
				end
			endcase
		end
	endtask

	initial begin
		logic [7:0] directed[$];
		logic [3:0] ch;
		note_event_t none;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset channel 0: stray data, extremes, running status, vel zero,
		// note off, real-time inside a pair, system common, status change
		directed = '{8'h3C, 8'h40,
			8'h90, 8'h00, 8'h7F, 8'h7F, 8'h01, 8'h3C, 8'h00,
			8'h80, 8'h45, 8'h40,
			8'h90, 8'h40, 8'hF8, 8'h50,
			8'h90, 8'h30, 8'hF7, 8'h40,
			8'h90, 8'h22, 8'hEF, 8'h90, 8'h23, 8'h24, 8'hFF};
		foreach (directed[i])
			midi_words_q.push_back(directed[i]);
		queue_note_traffic(PHASE_WORDS, 4'd0);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       ch = 4'd15;
				1:       ch = 4'd0;
				2:       ch = 4'd7;
				default: ch = 4'($urandom_range(0, 15));
			endcase
			write_channel(ch);
			if (phase == 0) begin
				directed = '{8'h9F, 8'h00, 8'h7F, 8'h90, 8'h10, 8'h20, 8'h8F, 8'h7F, 8'h00};
				foreach (directed[i])
					midi_words_q.push_back(directed[i]);
			end
			queue_note_traffic(PHASE_WORDS, ch);
		end

		while (midi_words_q.size() != 0 || in_valid)
			@(negedge clk);
		while (note_events_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		none = '0;
		while (note_events_due.size() != 0)
			report_event("missing event", note_events_due.pop_front(), none);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mnp_pkg.sv
rtl/mnp_note_freq.sv
rtl/midi_note_message_parser.sv
verif/midi_note_message_parser_test.sv
